### rtl/hba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hba_pkg - shared definitions for the horizontal bin average block
// Widths, register indexes, the bin word passed from front to back, and the
// divider state type.
// ---------------------------------------------------------------------------
package hba_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int MAX_FACTOR    = 64;
    localparam int MAX_ROW_WIDTH = 4096;

    localparam int FACTOR_BITS   = 7;     // bin_factor register width
    localparam int WIDTH_BITS    = 13;    // row_width register width
    localparam int COUNT_BITS    = $clog2(MAX_FACTOR) + 1;
    localparam int COL_BITS      = $clog2(MAX_ROW_WIDTH);
    localparam int SUM_BITS      = SAMPLE_BITS + $clog2(MAX_FACTOR);
    localparam int STEP_BITS     = $clog2(SUM_BITS);

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 13;

    localparam logic [CFG_IDX_BITS-1:0] REG_BIN_FACTOR = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_WIDTH  = 2'd1;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

    // one closed bin waiting for division
    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum;
        logic [COUNT_BITS-1:0]      count;
        logic                       row_end;
    } t_bin;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

endpackage
`default_nettype wire

### rtl/hba_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hba_front - pixel intake and bin accumulation
// Holds the configuration, sums pixels into the open bin, tracks the column
// and pushes each closed bin into the queue.
// ---------------------------------------------------------------------------
module hba_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [hba_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [hba_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                              i_pix_valid,
    output logic                                   o_pix_ready,
    input  wire logic signed [hba_pkg::SAMPLE_BITS-1:0] i_pixel,
    input  wire logic                              i_q_full,
    output logic                                   o_q_push,
    output hba_pkg::t_bin                          o_q_bin
);

    logic [hba_pkg::FACTOR_BITS-1:0]       r_bin_factor;
    logic [hba_pkg::WIDTH_BITS-1:0]        r_row_width;
    logic signed [hba_pkg::SUM_BITS-1:0]   r_sum;
    logic [hba_pkg::COUNT_BITS-1:0]        r_count;
    logic [hba_pkg::COL_BITS-1:0]          r_column;

    logic [hba_pkg::FACTOR_BITS-1:0]       eff_factor;
    logic [hba_pkg::WIDTH_BITS-1:0]        eff_width;
    logic signed [hba_pkg::SUM_BITS-1:0]   n_sum;
    logic [hba_pkg::COUNT_BITS-1:0]        n_count;
    logic                                  row_last;
    logic                                  bin_last;
    logic                                  accept;

    assign o_cfg_ready = 1'b1;
    assign o_pix_ready = !i_q_full;
    assign accept      = i_pix_valid && o_pix_ready;

    // out-of-range register values clamp
    always_comb begin
        if (r_bin_factor == '0) begin
            eff_factor = hba_pkg::FACTOR_BITS'(1);
        end else if (r_bin_factor > hba_pkg::FACTOR_BITS'(hba_pkg::MAX_FACTOR)) begin
            eff_factor = hba_pkg::FACTOR_BITS'(hba_pkg::MAX_FACTOR);
        end else begin
            eff_factor = r_bin_factor;
        end
        if (r_row_width == '0) begin
            eff_width = hba_pkg::WIDTH_BITS'(1);
        end else if (r_row_width > hba_pkg::WIDTH_BITS'(hba_pkg::MAX_ROW_WIDTH)) begin
            eff_width = hba_pkg::WIDTH_BITS'(hba_pkg::MAX_ROW_WIDTH);
        end else begin
            eff_width = r_row_width;
        end
    end

    always_comb begin
        n_sum    = r_sum + hba_pkg::SUM_BITS'(i_pixel);
        n_count  = r_count + 1'b1;
        row_last = (hba_pkg::WIDTH_BITS'(r_column) + 1'b1) >= eff_width;
        bin_last = (hba_pkg::WIDTH_BITS'(n_count) >= hba_pkg::WIDTH_BITS'(eff_factor))
                   || row_last;
    end

    assign o_q_push        = accept && bin_last;
    assign o_q_bin.sum     = n_sum;
    assign o_q_bin.count   = n_count;
    assign o_q_bin.row_end = row_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_factor <= hba_pkg::FACTOR_BITS'(1);
            r_row_width  <= hba_pkg::WIDTH_BITS'(hba_pkg::MAX_ROW_WIDTH);
            r_sum        <= '0;
            r_count      <= '0;
            r_column     <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    hba_pkg::REG_BIN_FACTOR: r_bin_factor <= i_cfg_data[hba_pkg::FACTOR_BITS-1:0];
                    hba_pkg::REG_ROW_WIDTH:  r_row_width  <= i_cfg_data[hba_pkg::WIDTH_BITS-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_column <= row_last ? '0 : r_column + 1'b1;
                if (bin_last) begin
                    r_sum   <= '0;
                    r_count <= '0;
                end else begin
                    r_sum   <= n_sum;
                    r_count <= n_count;
                end
            end
        end
    end

endmodule
`default_nettype wire

### rtl/hba_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hba_queue - short bin queue
// Small FIFO of closed bins between the accumulator and the divider.
// ---------------------------------------------------------------------------
module hba_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire hba_pkg::t_bin i_bin,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output hba_pkg::t_bin      o_bin
);

    hba_pkg::t_bin                  r_mem [hba_pkg::QUEUE_DEPTH];
    logic [hba_pkg::QPTR_BITS-1:0]  r_wr_ptr;
    logic [hba_pkg::QPTR_BITS-1:0]  r_rd_ptr;
    logic [hba_pkg::QPTR_BITS:0]    r_fill;

    assign o_full  = r_fill == (hba_pkg::QPTR_BITS+1)'(hba_pkg::QUEUE_DEPTH);
    assign o_empty = r_fill == '0;
    assign o_bin   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_bin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/hba_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hba_back - bin divider and output register
// Restoring divide of the bin magnitude by its count, one quotient bit per
// cycle, then sign fix-up into the output word register.
// ---------------------------------------------------------------------------
module hba_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    input  wire hba_pkg::t_bin i_q_bin,
    output logic               o_q_pop,
    output logic               o_avg_valid,
    input  wire logic          i_avg_ready,
    output logic signed [hba_pkg::SAMPLE_BITS-1:0] o_average,
    output logic               o_row_end
);

    hba_pkg::t_div_state                r_state;
    hba_pkg::t_div_state                n_state;

    logic [hba_pkg::SUM_BITS-1:0]       r_quo;      // dividend in, quotient out
    logic [hba_pkg::COUNT_BITS-1:0]     r_rem;
    logic [hba_pkg::COUNT_BITS-1:0]     r_div;
    logic [hba_pkg::STEP_BITS-1:0]      r_step;
    logic                               r_neg;
    logic                               r_row_end;

    logic                               r_out_valid;
    logic signed [hba_pkg::SAMPLE_BITS-1:0] r_out_avg;
    logic                               r_out_row_end;

    logic [hba_pkg::COUNT_BITS:0]       trial;
    logic                               trial_ge;
    logic [hba_pkg::SUM_BITS-1:0]       magnitude;
    logic [hba_pkg::SUM_BITS-1:0]       signed_quo;
    logic                               out_load;

    assign trial      = {r_rem, r_quo[hba_pkg::SUM_BITS-1]};
    assign trial_ge   = trial >= {1'b0, r_div};
    assign magnitude  = i_q_bin.sum[hba_pkg::SUM_BITS-1] ? -i_q_bin.sum : i_q_bin.sum;
    assign signed_quo = r_neg ? -r_quo : r_quo;

    always_comb begin
        n_state  = r_state;
        o_q_pop  = 1'b0;
        out_load = 1'b0;
        case (r_state)
            hba_pkg::DIV_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    // a single-pixel bin needs no division
                    n_state = (i_q_bin.count == hba_pkg::COUNT_BITS'(1)) ?
                              hba_pkg::DIV_DONE : hba_pkg::DIV_RUN;
                end
            end
            hba_pkg::DIV_RUN: begin
                if (r_step == '0) begin
                    n_state = hba_pkg::DIV_DONE;
                end
            end
            hba_pkg::DIV_DONE: begin
                if (!r_out_valid || i_avg_ready) begin
                    out_load = 1'b1;
                    n_state  = hba_pkg::DIV_IDLE;
                end
            end
            default: n_state = hba_pkg::DIV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hba_pkg::DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_quo     <= magnitude;
            r_rem     <= '0;
            r_div     <= i_q_bin.count;
            r_step    <= hba_pkg::STEP_BITS'(hba_pkg::SUM_BITS - 1);
            r_neg     <= i_q_bin.sum[hba_pkg::SUM_BITS-1];
            r_row_end <= i_q_bin.row_end;
        end else if (r_state == hba_pkg::DIV_RUN) begin
            r_quo  <= {r_quo[hba_pkg::SUM_BITS-2:0], trial_ge};
            r_rem  <= trial_ge ? hba_pkg::COUNT_BITS'(trial - {1'b0, r_div})
                               : trial[hba_pkg::COUNT_BITS-1:0];
            r_step <= r_step - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_avg_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_avg     <= signed_quo[hba_pkg::SAMPLE_BITS-1:0];
            r_out_row_end <= r_row_end;
        end
    end

    assign o_avg_valid = r_out_valid;
    assign o_average   = r_out_avg;
    assign o_row_end   = r_out_row_end;

endmodule
`default_nettype wire

### rtl/horizontal_bin_average.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// horizontal_bin_average - horizontal binning box-average downsampler
// Averages runs of bin_factor adjacent pixels of each raster row, with a
// short final bin at the row end, and flags the last average of a row.
// ---------------------------------------------------------------------------
// Pixels are accepted one per cycle as long as the four-entry bin queue has
// room; each accepted word is summed into the open bin at once. A closed bin
// is divided by its pixel count in a restoring divider that produces one
// quotient bit per cycle; each bin passes through a load, 22 divide steps and
// a hand-off, and a single-pixel bin skips the divide steps. When bins are
// small the divider falls behind, the queue fills and intake then drops
// below one pixel per cycle. Averages are truncated toward zero. Register 0
// is bin_factor (0 reads as 1, above 64 clamps to 64), register 1 is
// row_width (0 reads as 1, above 4096 clamps to 4096); both take effect on
// the next pixel and should be written while the block is idle.
// ---------------------------------------------------------------------------
module horizontal_bin_average (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [hba_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [hba_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    // pixel input channel
    input  wire logic                              i_pix_valid,
    output logic                                   o_pix_ready,
    input  wire logic signed [hba_pkg::SAMPLE_BITS-1:0] i_pixel,
    // average output channel
    output logic                                   o_avg_valid,
    input  wire logic                              i_avg_ready,
    output logic signed [hba_pkg::SAMPLE_BITS-1:0] o_average,
    output logic                                   o_row_end
);

    // front to queue
    logic          q_push;
    logic          q_full;
    hba_pkg::t_bin q_in_bin;

    // queue to back
    logic          q_pop;
    logic          q_empty;
    hba_pkg::t_bin q_out_bin;

    // accumulation and row tracking
    hba_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix_valid (i_pix_valid),
        .o_pix_ready (o_pix_ready),
        .i_pixel     (i_pixel),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_bin     (q_in_bin)
    );

    // decouples intake (one per cycle while not full) from the serial divide
    hba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_bin   (q_in_bin),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_bin   (q_out_bin)
    );

    // divide and present results
    hba_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_bin     (q_out_bin),
        .o_q_pop     (q_pop),
        .o_avg_valid (o_avg_valid),
        .i_avg_ready (i_avg_ready),
        .o_average   (o_average),
        .o_row_end   (o_row_end)
    );

endmodule
`default_nettype wire
